### rtl/mscrg_pkg.sv
package mscrg_pkg;

  localparam int unsigned MaxStops   = 8;
  localparam int unsigned MaxLength  = 4096;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned PosBits    = 16;
  localparam int unsigned IdxW       = $clog2(MaxStops);
  localparam int unsigned CntW       = $clog2(MaxStops + 1);
  localparam int unsigned LenW       = 13;
  localparam int unsigned AccW       = 8 + FracBits + 2;
  localparam int unsigned QuoW       = 8 + FracBits;

  localparam logic [1:0] FuncAdd     = 2'd0;
  localparam logic [1:0] FuncClear   = 2'd1;
  localparam logic [1:0] FuncRestart = 2'd2;
  localparam logic [1:0] FuncNext    = 2'd3;

  localparam logic [1:0] StColor     = 2'd0;
  localparam logic [1:0] StAck       = 2'd1;
  localparam logic [1:0] StFull      = 2'd2;
  localparam logic [1:0] StDone      = 2'd3;

  localparam logic [1:0] AddrFront   = 2'd0;
  localparam logic [1:0] AddrBack    = 2'd1;
  localparam logic [1:0] AddrLength  = 2'd2;

  // Divider control passed from the sequencer.
  typedef struct packed {
    logic                start;
    logic [7:0]          mag;
    logic [LenW-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [QuoW-1:0]     quot;
  } div_rsp_t;

  function automatic logic [7:0] chan_of(input logic [23:0] c, input logic [1:0] k);
    logic [7:0] r;
    r = 8'd0;
    case (k)
      2'd0:    r = c[23:16];
      2'd1:    r = c[15:8];
      2'd2:    r = c[7:0];
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] accum_to_chan(input logic signed [AccW-1:0] a);
    logic [AccW-1:0] v;
    logic [7:0] r;
    v = $unsigned(a) + (AccW'(1) << (FracBits - 1));
    if (a < 0) r = 8'd0;
    else if ((v >> FracBits) > AccW'(255)) r = 8'd255;
    else r = v[FracBits +: 8];
    return r;
  endfunction

endpackage

### rtl/mscrg_div.sv
module mscrg_div import mscrg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  // Restoring divider, one quotient bit per cycle: (mag << FracBits) / divisor.
  localparam int unsigned CW = $clog2(QuoW + 1);

  logic [QuoW-1:0] dividend_q, dividend_d;
  logic [QuoW-1:0] quot_q, quot_d;
  logic [LenW:0]   rem_q, rem_d;
  logic [LenW-1:0] dvs_q, dvs_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [LenW:0]   trial;

  always_comb begin
    dividend_d = dividend_q;
    quot_d     = quot_q;
    rem_d      = rem_q;
    dvs_d      = dvs_q;
    cnt_d      = cnt_q;
    busy_d     = busy_q;
    done_d     = 1'b0;
    trial      = {rem_q[LenW-1:0], dividend_q[QuoW-1]};
    if (req_i.start) begin
      dividend_d = {req_i.mag, FracBits'(0)};
      dvs_d      = req_i.divisor;
      rem_d      = '0;
      quot_d     = '0;
      cnt_d      = CW'(QuoW);
      busy_d     = 1'b1;
    end else if (busy_q) begin
      dividend_d = dividend_q << 1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        quot_d = {quot_q[QuoW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[QuoW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dividend_q <= dividend_d;
    quot_q     <= quot_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### rtl/multi_stop_color_ramp_generator_unit.sv
// Channel   | Direction | Handshake           | Payload
// config    | in/out    | APB psel/penable    | front_color, back_color, ramp_length
// command   | in        | start_i while !busy | func, stop_position, stop_color
// result    | out       | done_o strobe       | status, ramp_color, ramp_index, last_color
//
// A next color word inside an open segment passes the decode, update and emit states
// (SNext, SStep, SEmit) before its result shows; busy_o stays high through the result
// cycle, so the next word is accepted only after that result has shown.
// Opening a segment costs the multiply state (SMul) plus three serial divisions on the
// shared one-bit-a-cycle divider.
// Adding a stop shifts the table one entry a cycle.
// Reset is asynchronous and active low; stop tables are not cleared.
// The receiver cannot stall: each result shows for one cycle on done_o.
module multi_stop_color_ramp_generator_unit import mscrg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] stop_position_i,
  input  logic [23:0] stop_color_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [23:0] ramp_color_o,
  output logic [11:0] ramp_index_o,
  output logic        last_color_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SShift = 4'd1;
  localparam logic [3:0] SNext  = 4'd2;
  localparam logic [3:0] SOpen  = 4'd3;
  localparam logic [3:0] SMul   = 4'd4;
  localparam logic [3:0] SDiv   = 4'd5;
  localparam logic [3:0] SDivW  = 4'd6;
  localparam logic [3:0] SStep  = 4'd7;
  localparam logic [3:0] SEmit  = 4'd8;

  // Configuration registers.
  logic [23:0]     front_q, back_q;
  logic [LenW-1:0] rlen_q;
  logic            wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= 24'h000000;
      back_q  <= 24'hFFFFFF;
      rlen_q  <= LenW'(256);
    end else if (wr_en) begin
      case (paddr[3:2])
        AddrFront:  front_q <= pwdata[23:0];
        AddrBack:   back_q  <= pwdata[23:0];
        AddrLength: rlen_q  <= pwdata[LenW-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      AddrFront:  prdata = {8'd0, front_q};
      AddrBack:   prdata = {8'd0, back_q};
      AddrLength: prdata = {{(32-LenW){1'b0}}, rlen_q};
      default:    prdata = 32'd0;
    endcase
  end

  // Effective length, clamped into 2..MaxLength.
  logic [LenW-1:0] len;
  always_comb begin
    if (rlen_q < LenW'(2)) len = LenW'(2);
    else if (rlen_q > LenW'(MaxLength)) len = LenW'(MaxLength);
    else len = rlen_q;
  end

  // Stop tables.
  logic [15:0] pos_tab_q [MaxStops];
  logic [23:0] col_tab_q [MaxStops];

  logic [3:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   seg_q, seg_d;
  logic [CntW-1:0]   j_q, j_d;
  logic [LenW-1:0]   ticks_q, ticks_d, emit_q, emit_d, cov_q, cov_d;
  logic [15:0]       prev_q, prev_d;
  logic signed [AccW-1:0] acc_q [3];
  logic signed [AccW-1:0] acc_d [3];
  logic signed [AccW-1:0] stp_q [3];
  logic signed [AccW-1:0] stp_d [3];
  logic [1:0]        k_q, k_d;
  logic [LenW-1:0]   dist_q, dist_d;
  logic [23:0]       sc_q, sc_d, ec_q, ec_d;
  logic [LenW+PosBits-1:0] prod_q, prod_d;
  logic [15:0]       in_pos_q, in_pos_d;
  logic [23:0]       in_col_q, in_col_d;
  logic              tab_we;
  logic [IdxW-1:0]   tab_wa;
  logic [15:0]       tab_wp;
  logic [23:0]       tab_wc;

  logic        done_d, done_q, last_d, last_q;
  logic [1:0]  st_d, st_q;
  logic [23:0] rc_d, rc_q;
  logic [11:0] ri_d, ri_q;

  div_req_t dreq;
  div_rsp_t drsp;
  mscrg_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic [LenW-1:0] room;
  logic [IdxW-1:0] seg_ix, segm1_ix, jm1_ix;
  logic signed [9:0] diff;
  logic [7:0]  mag;
  logic [LenW-1:0] dist_raw;
  assign room     = (cov_q < len - LenW'(1)) ? (len - LenW'(1) - cov_q) : '0;
  assign seg_ix   = seg_q[IdxW-1:0];
  assign segm1_ix = IdxW'(seg_q - CntW'(1));
  assign jm1_ix   = IdxW'(j_q - CntW'(1));
  assign diff     = $signed({2'b00, chan_of(ec_q, k_q)}) - $signed({2'b00, chan_of(sc_q, k_q)});
  assign mag      = diff[9] ? 8'(-diff) : diff[7:0];
  assign dist_raw = prod_q[PosBits +: LenW];

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; seg_d = seg_q; j_d = j_q;
    ticks_d = ticks_q; emit_d = emit_q; cov_d = cov_q; prev_d = prev_q;
    acc_d = acc_q; stp_d = stp_q; k_d = k_q; dist_d = dist_q;
    sc_d = sc_q; ec_d = ec_q; prod_d = prod_q; in_pos_d = in_pos_q;
    in_col_d = in_col_q;
    tab_we = 1'b0; tab_wa = '0; tab_wp = in_pos_q; tab_wc = in_col_q;
    done_d = 1'b0; st_d = StAck; rc_d = '0; ri_d = '0; last_d = 1'b0;
    dreq.start = 1'b0; dreq.mag = mag; dreq.divisor = dist_q;
    case (state_q)
      SIdle: begin
        // The result cycle still counts as busy, so no word is taken then.
        if (start_i && !done_q) begin
          case (func_i)
            FuncAdd: begin
              if (cnt_q >= CntW'(MaxStops)) begin
                done_d = 1'b1; st_d = StFull;
              end else begin
                in_pos_d = stop_position_i; in_col_d = stop_color_i;
                j_d = cnt_q; state_d = SShift;
              end
            end
            FuncClear, FuncRestart: begin
              if (func_i == FuncClear) cnt_d = '0;
              seg_d = '0; ticks_d = '0; emit_d = '0; cov_d = '0; prev_d = '0;
              done_d = 1'b1; st_d = StAck;
            end
            default: state_d = SNext;
          endcase
        end
      end
      SShift: begin
        if (j_q != '0 && pos_tab_q[jm1_ix] > in_pos_q) begin
          tab_we = 1'b1; tab_wa = IdxW'(j_q);
          tab_wp = pos_tab_q[jm1_ix]; tab_wc = col_tab_q[jm1_ix];
          j_d = j_q - CntW'(1);
        end else begin
          tab_we = 1'b1; tab_wa = IdxW'(j_q);
          cnt_d = cnt_q + CntW'(1);
          seg_d = '0; ticks_d = '0; emit_d = '0; cov_d = '0; prev_d = '0;
          done_d = 1'b1; st_d = StAck; state_d = SIdle;
        end
      end
      SNext: begin
        state_d = SIdle;
        done_d = 1'b1;
        if ({1'b0, emit_q} >= {1'b0, len}) begin
          st_d = StDone;
        end else if (emit_q == len - LenW'(1)) begin
          st_d = StColor; rc_d = back_q; ri_d = emit_q[11:0]; last_d = 1'b1;
          emit_d = emit_q + LenW'(1);
        end else if (ticks_q != '0) begin
          done_d = 1'b0; state_d = SStep;
        end else begin
          done_d = 1'b0; state_d = SOpen;
        end
      end
      SOpen: begin
        if (seg_q > cnt_q) begin
          done_d = 1'b1; st_d = StColor; rc_d = back_q; ri_d = emit_q[11:0];
          emit_d = emit_q + LenW'(1); state_d = SIdle;
        end else begin
          sc_d = (seg_q == '0) ? front_q : col_tab_q[segm1_ix];
          if (seg_q < cnt_q) begin
            ec_d = col_tab_q[seg_ix];
            prod_d = (pos_tab_q[seg_ix] > prev_q)
                   ? (LenW+PosBits)'(pos_tab_q[seg_ix] - prev_q) * (LenW+PosBits)'(len)
                   : '0;
            prev_d = pos_tab_q[seg_ix];
          end else begin
            ec_d = back_q;
            prod_d = {room, PosBits'(0)};
          end
          seg_d = seg_q + CntW'(1);
          state_d = SMul;
        end
      end
      SMul: begin
        dist_d = (dist_raw > room) ? room : dist_raw;
        if (((dist_raw > room) ? room : dist_raw) == '0) begin
          state_d = SOpen;
        end else begin
          k_d = 2'd0; state_d = SDiv;
        end
      end
      SDiv: begin
        dreq.start = 1'b1; state_d = SDivW;
      end
      SDivW: begin
        if (drsp.done) begin
          stp_d[k_q] = diff[9] ? -$signed({2'b00, drsp.quot}) : $signed({2'b00, drsp.quot});
          acc_d[k_q] = $signed({2'b00, chan_of(sc_q, k_q), FracBits'(0)});
          if (k_q == 2'd2) begin
            cov_d = cov_q + dist_q; ticks_d = dist_q;
            state_d = SStep;
          end else begin
            k_d = k_q + 2'd1; state_d = SDiv;
          end
        end
      end
      SStep: begin
        // The accumulators move only when emitted plus remaining entries
        // differ from the covered distance.
        if (({1'b0, emit_q} + {1'b0, ticks_q}) != {1'b0, cov_q}) begin
          for (int k = 0; k < 3; k++) acc_d[k] = acc_q[k] + stp_q[k];
        end
        state_d = SEmit;
      end
      SEmit: begin
        done_d = 1'b1; st_d = StColor; ri_d = emit_q[11:0];
        rc_d = {accum_to_chan(acc_q[0]), accum_to_chan(acc_q[1]), accum_to_chan(acc_q[2])};
        ticks_d = ticks_q - LenW'(1);
        emit_d = emit_q + LenW'(1);
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cnt_q <= '0; seg_q <= '0; ticks_q <= '0;
      emit_q <= '0; cov_q <= '0; prev_q <= '0; done_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; seg_q <= seg_d; ticks_q <= ticks_d;
      emit_q <= emit_d; cov_q <= cov_d; prev_q <= prev_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d; acc_q <= acc_d; stp_q <= stp_d; k_q <= k_d; dist_q <= dist_d;
    sc_q <= sc_d; ec_q <= ec_d; prod_q <= prod_d; in_pos_q <= in_pos_d;
    in_col_q <= in_col_d;
    st_q <= st_d; rc_q <= rc_d; ri_q <= ri_d; last_q <= last_d;
    if (tab_we) begin
      pos_tab_q[tab_wa] <= tab_wp;
      col_tab_q[tab_wa] <= tab_wc;
    end
  end

  assign busy_o       = (state_q != SIdle) || done_q;
  assign done_o       = done_q;
  assign status_o     = st_q;
  assign ramp_color_o = rc_q;
  assign ramp_index_o = ri_q;
  assign last_color_o = last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxStops)) else $error("stop count overflow");
  a_cov_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> (ticks_q <= cov_q)) else $error("ticks exceed covered");
  a_last_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && last_q) |-> (st_q == StColor)) else $error("last without color");
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("double result");

endmodule

### test/multi_stop_color_ramp_generator_unit_test.sv
module multi_stop_color_ramp_generator_unit_test;
  import mscrg_pkg::*;

  // Each command word yields exactly one result word on done_o. Opening a
  // segment runs three divisions on the serial divider, so drain_results keeps
  // waiting after the last expected word, before register writes and at the end.
  localparam int unsigned DrainCycles = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  func_i;
  logic [15:0] stop_position_i;
  logic [23:0] stop_color_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [23:0] ramp_color_o;
  logic [11:0] ramp_index_o;
  logic        last_color_o;

  multi_stop_color_ramp_generator_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .stop_position_i(stop_position_i),
    .stop_color_i   (stop_color_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .ramp_color_o   (ramp_color_o),
    .ramp_index_o   (ramp_index_o),
    .last_color_o   (last_color_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // One result word as the block presents it.
  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] color;
    logic [11:0] index;
    logic        last;
  } ramp_word_t;

  // A row of the directed table. When check_fixed is set, the typed-in
  // result must also agree with the predictor's result.
  typedef struct {
    logic [1:0]  func;
    logic [15:0] pos;
    logic [23:0] color;
    bit          check_fixed;
    ramp_word_t  fixed;
  } cmd_row_t;

  // Shadow of the configuration registers and the ramp state.
  logic [23:0]        shadow_front;
  logic [23:0]        shadow_back;
  logic [12:0]        shadow_length;
  logic [15:0]        stop_pos_q [MaxStops];
  logic [23:0]        stop_col_q [MaxStops];
  int unsigned        num_stops;
  int unsigned        seg_sel;
  int unsigned        seg_left;
  int unsigned        colors_out;
  int unsigned        span_done;
  int unsigned        last_pos;
  longint             accum [3];
  longint             step [3];

  ramp_word_t         pending_words [$];
  int unsigned        mismatch_count;
  int unsigned        sender_idle_pct;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic void restart_shadow();
    seg_sel    = 0;
    seg_left   = 0;
    colors_out = 0;
    span_done  = 0;
    last_pos   = 0;
    for (int k = 0; k < 3; k++) begin
      accum[k] = 0;
      step[k]  = 0;
    end
  endfunction

  function automatic int unsigned live_length();
    if (shadow_length < 2) return 2;
    if (shadow_length > MaxLength) return MaxLength;
    return shadow_length;
  endfunction

  function automatic longint channel_of(input logic [23:0] c, input int k);
    return longint'((c >> (16 - 8 * k)) & 24'hFF);
  endfunction

  function automatic logic [7:0] round_channel(input longint a);
    longint v;
    if (a < 0) return 8'd0;
    v = (a + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Advance to the next segment that has at least one entry.
  function automatic bit bool_open(input int unsigned len);
    int unsigned seg_len;
    int unsigned room;
    logic [23:0] from_col;
    logic [23:0] to_col;
    longint      diff;
    longint      mag;
    longint      quot;
    while (seg_left == 0 && seg_sel <= num_stops) begin
      from_col = (seg_sel == 0) ? shadow_front : stop_col_q[seg_sel - 1];
      room = (span_done < len - 1) ? (len - 1 - span_done) : 0;
      if (seg_sel < num_stops) begin
        to_col = stop_col_q[seg_sel];
        seg_len = (stop_pos_q[seg_sel] > last_pos)
          ? int'((longint'(stop_pos_q[seg_sel] - last_pos) * len) >> PosBits) : 0;
        last_pos = stop_pos_q[seg_sel];
      end else begin
        to_col = shadow_back;
        seg_len = room;
      end
      if (seg_len > room) seg_len = room;
      seg_sel++;
      if (seg_len != 0) begin
        span_done += seg_len;
        seg_left = seg_len;
        for (int k = 0; k < 3; k++) begin
          diff = channel_of(to_col, k) - channel_of(from_col, k);
          mag = (diff < 0) ? -diff : diff;
          quot = (mag <<< FracBits) / seg_len;
          step[k] = (diff < 0) ? -quot : quot;
          accum[k] = channel_of(from_col, k) <<< FracBits;
        end
      end
    end
    return seg_left != 0;
  endfunction

  // Predict the result word for one command and update the shadow state.
  function automatic ramp_word_t predict_ramp_word(input logic [1:0] func,
                                                    input logic [15:0] pos,
                                                    input logic [23:0] color);
    ramp_word_t  w;
    int unsigned len;
    int unsigned j;
    bit          first;
    w = '{status: StAck, color: 24'd0, index: 12'd0, last: 1'b0};
    case (func)
      FuncAdd: begin
        if (num_stops >= MaxStops) begin
          w.status = StFull;
        end else begin
          j = num_stops;
          while (j > 0 && stop_pos_q[j - 1] > pos) begin
            stop_pos_q[j] = stop_pos_q[j - 1];
            stop_col_q[j] = stop_col_q[j - 1];
            j--;
          end
          stop_pos_q[j] = pos;
          stop_col_q[j] = color;
          num_stops++;
          restart_shadow();
        end
      end
      FuncClear: begin
        num_stops = 0;
        restart_shadow();
      end
      FuncRestart: begin
        restart_shadow();
      end
      default: begin
        len = live_length();
        if (colors_out >= len) begin
          w.status = StDone;
        end else if (colors_out == len - 1) begin
          w.status = StColor;
          w.color  = shadow_back;
          w.index  = colors_out[11:0];
          w.last   = 1'b1;
          colors_out++;
        end else begin
          w.status = StColor;
          w.index  = colors_out[11:0];
          if (bool_open(len)) begin
            first = (colors_out + seg_left == span_done);
            for (int k = 0; k < 3; k++) begin
              if (!first) accum[k] += step[k];
              w.color[16 - 8 * k +: 8] = round_channel(accum[k]);
            end
            seg_left--;
          end else begin
            w.color = shadow_back;
          end
          colors_out++;
        end
      end
    endcase
    return w;
  endfunction

  // Result checker: every done_o strobe consumes the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, status", status_o, 0);
      end else begin
        ramp_word_t want;
        want = pending_words.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (ramp_color_o !== want.color) report_mismatch("ramp_color", ramp_color_o, want.color);
        if (ramp_index_o !== want.index) report_mismatch("ramp_index", ramp_index_o, want.index);
        if (last_color_o !== want.last) report_mismatch("last_color", last_color_o, want.last);
      end
    end
  end

  // Register write over the APB port; only used while the block is idle.
  task automatic write_reg(input logic [1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {addr, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (addr)
      AddrFront: shadow_front  = data[23:0];
      AddrBack:  shadow_back   = data[23:0];
      default:   shadow_length = data[12:0];
    endcase
  endtask

  // Issue one command word, honoring busy_o, with optional idle gaps first.
  // start_i stays high after acceptance until the next idle gap or drain.
  task automatic send_cmd(input logic [1:0] func, input logic [15:0] pos,
                          input logic [23:0] color, output ramp_word_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    func_i          <= func;
    stop_position_i <= pos;
    stop_color_i    <= color;
    do @(posedge clk_i); while (busy_o);
    want = predict_ramp_word(func, pos, color);
    pending_words = {pending_words, want};
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_position();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Random phase: mostly walks ramps with next commands, with occasional
  // adds, clears and restarts in between.
  task automatic random_phase(input int unsigned n_items);
    ramp_word_t  want;
    int unsigned sel;
    for (int unsigned i = 0; i < n_items; i++) begin
      sel = $urandom_range(99);
      if (sel < 6) begin
        send_cmd(FuncAdd, random_position(), 24'($urandom), want);
      end else if (sel < 8) begin
        send_cmd(FuncClear, 16'($urandom), 24'($urandom), want);
      end else if (sel < 10) begin
        send_cmd(FuncRestart, 16'($urandom), 24'($urandom), want);
      end else begin
        send_cmd(FuncNext, 16'($urandom), 24'($urandom), want);
      end
    end
  endtask

  cmd_row_t   directed_rows [$];
  ramp_word_t dir_want;
  logic [12:0] lengths [6] = '{13'd2, 13'd4096, 13'd0, 13'd8191, 13'd5, 13'd23};
  int unsigned idle_pcts [4] = '{0, 56, 0, 23};

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    start_i         = 1'b0;
    func_i          = FuncRestart;
    stop_position_i = '0;
    stop_color_i    = '0;
    mismatch_count  = 0;
    sender_idle_pct = 0;
    shadow_front    = 24'h000000;
    shadow_back     = 24'hFFFFFF;
    shadow_length   = 13'd256;
    num_stops       = 0;
    for (int i = 0; i < MaxStops; i++) begin
      stop_pos_q[i] = '0;
      stop_col_q[i] = '0;
    end
    restart_shadow();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: first color after reset is the front color, then ties,
    // a zero position, a full table, further next words, a restart and a clear.
    directed_rows = '{
      '{FuncNext, 16'd0, 24'd0, 1'b1, '{StColor, 24'h000000, 12'd0, 1'b0}},
      '{FuncNext, 16'd0, 24'd0, 1'b0, '{StColor, 24'h0, 12'd0, 1'b0}},
      '{FuncAdd, 16'h8000, 24'hFF0000, 1'b1, '{StAck, 24'h0, 12'd0, 1'b0}},
      '{FuncAdd, 16'h8000, 24'h00FF00, 1'b1, '{StAck, 24'h0, 12'd0, 1'b0}},
      '{FuncAdd, 16'h0000, 24'h0000FF, 1'b1, '{StAck, 24'h0, 12'd0, 1'b0}},
      '{FuncAdd, 16'hFFFF, 24'hFFFFFF, 1'b1, '{StAck, 24'h0, 12'd0, 1'b0}},
      '{FuncAdd, 16'h0001, 24'h123456, 1'b1, '{StAck, 24'h0, 12'd0, 1'b0}},
      '{FuncAdd, 16'h4000, 24'hABCDEF, 1'b1, '{StAck, 24'h0, 12'd0, 1'b0}},
      '{FuncAdd, 16'hC000, 24'h808080, 1'b1, '{StAck, 24'h0, 12'd0, 1'b0}},
      '{FuncAdd, 16'h2000, 24'h5A5AA5, 1'b1, '{StAck, 24'h0, 12'd0, 1'b0}},
      '{FuncAdd, 16'h3000, 24'h111111, 1'b1, '{StFull, 24'h0, 12'd0, 1'b0}},
      '{FuncNext, 16'd0, 24'd0, 1'b0, '{StColor, 24'h0, 12'd0, 1'b0}},
      '{FuncNext, 16'd0, 24'd0, 1'b0, '{StColor, 24'h0, 12'd0, 1'b0}},
      '{FuncNext, 16'd0, 24'd0, 1'b0, '{StColor, 24'h0, 12'd0, 1'b0}},
      '{FuncRestart, 16'hFFFF, 24'hFFFFFF, 1'b1, '{StAck, 24'h0, 12'd0, 1'b0}},
      '{FuncClear, 16'd0, 24'd0, 1'b1, '{StAck, 24'h0, 12'd0, 1'b0}}
    };
    foreach (directed_rows[r]) begin
      send_cmd(directed_rows[r].func, directed_rows[r].pos, directed_rows[r].color, dir_want);
      if (directed_rows[r].check_fixed && dir_want !== directed_rows[r].fixed)
        report_mismatch("directed row expectation", dir_want, directed_rows[r].fixed);
    end

    // A two-entry ramp: front, then back with the last flag, then finished.
    drain_results();
    write_reg(AddrLength, 32'd2);
    write_reg(AddrFront, 32'h00FF00FF);
    write_reg(AddrBack, 32'hFF00FF00);
    send_cmd(FuncNext, 16'd0, 24'd0, dir_want);
    if (dir_want !== ramp_word_t'{StColor, 24'hFF00FF, 12'd0, 1'b0})
      report_mismatch("short ramp first", dir_want, 0);
    send_cmd(FuncNext, 16'd0, 24'd0, dir_want);
    if (dir_want !== ramp_word_t'{StColor, 24'h00FF00, 12'd1, 1'b1})
      report_mismatch("short ramp last", dir_want, 0);
    send_cmd(FuncNext, 16'd0, 24'd0, dir_want);
    if (dir_want !== ramp_word_t'{StDone, 24'h0, 12'd0, 1'b0})
      report_mismatch("short ramp done", dir_want, 0);

    // Random phases over several register settings and idle rates. Short
    // ramps dominate; the longest lengths appear in one phase each.
    for (int p = 0; p < 12; p++) begin
      drain_results();
      write_reg(AddrFront, (p == 1) ? 32'hFFFFFFFF : 32'($urandom));
      write_reg(AddrBack, (p == 2) ? 32'h0 : 32'($urandom));
      write_reg(AddrLength, (p < 6) ? 32'(lengths[p]) : 32'($urandom_range(2, 40)));
      sender_idle_pct = idle_pcts[p % 4];
      random_phase((p == 1 || p == 3) ? 60 : 170);
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
